[rtl/plpt_pkg.sv]
// Shared types and constants of the piecewise-linear point table.
package plpt_pkg;

  localparam int unsigned TABLE_SIZE = 64;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int unsigned ENTRY_W    = 32;
  // rounded quotient: dividend 2*|num| + den, divisor 2*den
  localparam int unsigned DVD_W      = 44;
  localparam int unsigned DVS_W      = 17;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SH_VARY  = 3'd0,
    SH_FALL  = 3'd1,
    SH_RISE  = 3'd2,
    SH_CONST = 3'd3,
    SH_NONE  = 3'd4
  } shape_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

[rtl/plpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/plpt_div.sv]
// Restoring divider, one quotient bit per cycle.
module plpt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plpt_pkg::div_req_t        req_i,
  output logic                      done_o,
  output logic [plpt_pkg::DVD_W-1:0] quotient_o
);
  import plpt_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   trial;

  assign trial      = {rem_q, quo_q[DVD_W-1]};
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = DVS_W'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DVS_W-1:0];
          quo_d = {quo_q[DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

endmodule

[rtl/piecewise_linear_point_table.sv]
// Piecewise-linear point table: sorted point store with interpolating lookup.
//
// Input channel (in_valid_i / in_stall_o) takes one item: mode 0 inserts
// (point_x_i, point_y_i) at its sorted place, mode 1 evaluates query_x_i
// (8 fraction bits). Each item gives exactly one result on the output
// channel (out_valid_o / out_stall_i) together with the table's bounds,
// count and shape class.
// One item at a time: in_stall_o is high from acceptance until the result
// is loaded into the output register. Insert walks from the top entry
// down through the single-read point memory. Evaluate walks up the memory
// to the bracketing entry, then goes through the multiply states S_MUL1
// and S_MUL2 and a 44-step bit-serial divider.
// An early-out item (full, empty, out of range) goes straight to the result.
// A stalled result holds in the output register; the next item may be
// accepted, but its own result waits until the register is freed.
// Reset empties the table; memory contents need no clearing since only
// entries below the count are ever read.
module piecewise_linear_point_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic signed [15:0]     point_x_i,
  input  logic signed [15:0]     point_y_i,
  input  logic signed [23:0]     query_x_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [31:0]     value_o,
  output logic [2:0]             shape_class_o,
  output logic signed [15:0]     lowest_x_o,
  output logic signed [15:0]     highest_x_o,
  output logic [6:0]             point_count_o,
  output logic [1:0]             status_o
);
  import plpt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_IRD  = 9'b000000010,
    S_ICMP = 9'b000000100,
    S_ERD  = 9'b000001000,
    S_ECMP = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_MUL2 = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    C_UP   = 2'd0,
    C_DOWN = 2'd1,
    C_FLAT = 2'd2
  } step_e;

  function automatic step_e step_of(logic signed [15:0] a, logic signed [15:0] b);
    if (b > a) return C_UP;
    else if (b < a) return C_DOWN;
    else return C_FLAT;
  endfunction

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] n_up_q, n_up_d, n_dn_q, n_dn_d, n_fl_q, n_fl_d;
  logic signed [15:0] low_q, low_d, high_q, high_d;

  // item payload and walk scratch
  logic signed [15:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [23:0] qx_q, qx_d;
  logic               have_hi_q, have_hi_d;
  logic signed [15:0] yhi_q, yhi_d;
  logic signed [15:0] xl_q, xl_d, yl_q, yl_d, xh_q, xh_d, yh_q, yh_d;
  logic signed [40:0] p1_q, p1_d;
  logic signed [41:0] num_q, num_d;
  logic signed [31:0] res_val_q, res_val_d;
  status_e            res_st_q, res_st_d;

  logic               out_valid_q;
  logic signed [31:0] value_q;
  logic [2:0]         shape_q;
  logic signed [15:0] lowest_q, highest_q;
  logic [CNT_W-1:0]   pcount_q;
  status_e            status_q;

  // memory
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic signed [15:0] dx, dy;
  logic signed [23:0] dX;

  // divider
  div_req_t           div_req;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;
  logic               div_busy_q;

  // placement bookkeeping
  logic               place, place_lo;
  logic signed [15:0] place_ylo;
  step_e              c_old, c_lo, c_hi;
  logic               load_out;
  shape_e             shape_now;
  logic [41:0]        num_mag;
  logic [16:0]        den;
  logic signed [24:0] dq_hi, dq_lo;

  assign dx = rdata[31:16];
  assign dy = rdata[15:0];
  assign dX = {dx, 8'h00};

  plpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  plpt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign raddr = (state_q == S_IRD) ? IDX_W'(pos_q - 1'b1) : pos_q[IDX_W-1:0];

  assign num_mag = num_q[41] ? 42'(-num_q) : 42'(num_q);
  assign den     = 17'(18'(xh_q) - 18'(xl_q));
  assign dq_hi   = 25'($signed({xh_q, 8'h00})) - 25'(qx_q);
  assign dq_lo   = 25'(qx_q) - 25'($signed({xl_q, 8'h00}));

  always_comb begin
    div_req          = '0;
    div_req.dividend = DVD_W'({num_mag, 1'b0}) + DVD_W'(den);
    div_req.divisor  = DVS_W'({den, 1'b0});
    div_req.start    = (state_q == S_DIV) && !div_busy_q;
  end

  always_comb begin
    if (count_q < CNT_W'(2)) shape_now = SH_NONE;
    else if (n_up_q != '0 && n_dn_q != '0) shape_now = SH_VARY;
    else if (n_dn_q != '0 && n_fl_q == '0) shape_now = SH_FALL;
    else if (n_up_q != '0 && n_fl_q == '0) shape_now = SH_RISE;
    else if (n_fl_q != '0 && n_up_q == '0 && n_dn_q == '0) shape_now = SH_CONST;
    else shape_now = SH_NONE;
  end

  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    n_up_d    = n_up_q;
    n_dn_d    = n_dn_q;
    n_fl_d    = n_fl_q;
    low_d     = low_q;
    high_d    = high_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    qx_d      = qx_q;
    have_hi_d = have_hi_q;
    yhi_d     = yhi_q;
    xl_d      = xl_q;
    yl_d      = yl_q;
    xh_d      = xh_q;
    yh_d      = yh_q;
    p1_d      = p1_q;
    num_d     = num_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    we        = 1'b0;
    waddr     = pos_q[IDX_W-1:0];
    wdata     = {nx_q, ny_q};
    place     = 1'b0;
    place_lo  = 1'b0;
    place_ylo = dy;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          nx_d      = point_x_i;
          ny_d      = point_y_i;
          qx_d      = query_x_i;
          pos_d     = '0;
          have_hi_d = 1'b0;
          res_val_d = '0;
          res_st_d  = ST_OK;
          if (!mode_i) begin
            if (count_q == CNT_W'(TABLE_SIZE)) begin
              res_st_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              pos_d   = count_q;
              state_d = S_IRD;
            end
          end else if (count_q == '0) begin
            res_st_d = ST_EMPTY;
            state_d  = S_FIN;
          end else if (query_x_i < $signed({low_q, 8'h00}) ||
                       query_x_i > $signed({high_q, 8'h00})) begin
            res_st_d = ST_RANGE;
            state_d  = S_FIN;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      S_IRD: begin
        if (pos_q == '0) begin
          place = 1'b1;
        end else begin
          state_d = S_ICMP;
        end
      end
      S_ICMP: begin
        if (dx > nx_q) begin
          // shift this entry up one place
          we        = 1'b1;
          wdata     = rdata;
          have_hi_d = 1'b1;
          yhi_d     = dy;
          pos_d     = pos_q - 1'b1;
          state_d   = S_IRD;
        end else begin
          place    = 1'b1;
          place_lo = 1'b1;
        end
      end
      S_ERD: state_d = S_ECMP;
      S_ECMP: begin
        if (dX == qx_q) begin
          res_val_d = 32'(dy) <<< 8;
          state_d   = S_FIN;
        end else if (dX > qx_q) begin
          xh_d    = dx;
          yh_d    = dy;
          state_d = S_MUL1;
        end else begin
          xl_d    = dx;
          yl_d    = dy;
          pos_d   = pos_q + 1'b1;
          state_d = S_ERD;
        end
      end
      S_MUL1: begin
        p1_d    = 41'(yl_q) * 41'(dq_hi);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        num_d   = 42'(p1_q) + 42'(yh_q) * 42'(dq_lo);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_val_d = num_q[41] ? -32'(div_quo[31:0]) : 32'(div_quo[31:0]);
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (place) begin
      we      = 1'b1;
      wdata   = {nx_q, ny_q};
      count_d = count_q + 1'b1;
      if (pos_q == '0) low_d = nx_q;
      if (!have_hi_q) high_d = nx_q;
      state_d = S_FIN;
    end
  end

  assign c_old = step_of(place_ylo, yhi_q);
  assign c_lo  = step_of(place_ylo, ny_q);
  assign c_hi  = step_of(ny_q, yhi_q);

  logic [CNT_W-1:0] up_next, dn_next, fl_next;
  always_comb begin
    up_next = n_up_q;
    dn_next = n_dn_q;
    fl_next = n_fl_q;
    if (place_lo && have_hi_q) begin
      unique case (c_old)
        C_UP:    up_next = up_next - 1'b1;
        C_DOWN:  dn_next = dn_next - 1'b1;
        default: fl_next = fl_next - 1'b1;
      endcase
    end
    if (place_lo) begin
      unique case (c_lo)
        C_UP:    up_next = up_next + 1'b1;
        C_DOWN:  dn_next = dn_next + 1'b1;
        default: fl_next = fl_next + 1'b1;
      endcase
    end
    if (have_hi_q) begin
      unique case (c_hi)
        C_UP:    up_next = up_next + 1'b1;
        C_DOWN:  dn_next = dn_next + 1'b1;
        default: fl_next = fl_next + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      n_up_q      <= '0;
      n_dn_q      <= '0;
      n_fl_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
      div_busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
      if (place) begin
        n_up_q <= up_next;
        n_dn_q <= dn_next;
        n_fl_q <= fl_next;
      end
      if (div_req.start) div_busy_q <= 1'b1;
      else if (div_done) div_busy_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    qx_q      <= qx_d;
    have_hi_q <= have_hi_d;
    yhi_q     <= yhi_d;
    xl_q      <= xl_d;
    yl_q      <= yl_d;
    xh_q      <= xh_d;
    yh_q      <= yh_d;
    p1_q      <= p1_d;
    num_q     <= num_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (load_out) begin
      value_q   <= res_val_q;
      shape_q   <= shape_now;
      lowest_q  <= low_q;
      highest_q <= high_q;
      pcount_q  <= count_q;
      status_q  <= res_st_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign shape_class_o = shape_q;
  assign lowest_x_o    = lowest_q;
  assign highest_x_o   = highest_q;
  assign point_count_o = 7'(pcount_q);
  assign status_o      = status_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_SIZE)) else $error("point count above table size");
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> point_count_o == 7'(TABLE_SIZE))
    else $error("table full reported below capacity");
  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> value_o == '0)
    else $error("non-zero value on failed item");
  a_div_in_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside evaluate");
`endif

endmodule
